// File: sv/stb_pkg.sv
`timescale 1ns / 1ps
package stb_pkg;

  // operation codes carried by func
  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_STOP   = 3'd1,
    FN_START  = 3'd2,
    FN_TMO    = 3'd3,
    FN_RUN    = 3'd4,
    FN_SELECT = 3'd5,
    FN_NEXT   = 3'd6
  } func_e;

  localparam int unsigned TIMER_COUNT_MAX   = 32;
  localparam logic [31:0] START_DELAY_RESET = 32'd2000;
  localparam logic [30:0] NO_DEADLINE       = 31'h7fff_ffff;

  // configuration register byte addresses
  localparam logic [2:0] REG_START_DELAY = 3'd0;

  localparam logic [1:0] POP_NONE = 2'd0;
  localparam logic [1:0] POP_ONE  = 2'd1;
  localparam logic [1:0] POP_TWO  = 2'd2;

  typedef struct packed {
    logic        status;
    logic        has_value;
    logic [30:0] value;
    logic [1:0]  pop_count;
    logic [31:0] input_mask_out;
  } result_t;

endpackage

// File: sv/software_timer_bank.sv
// Bank of one-shot deadline timers on a millisecond counter that tick words advance.
// Input channel (in_valid_i / in_stall_o) carries one operation word per
// item: func_i selects tick, stop, start, timeout query, running query,
// select or next. The output channel (out_valid_o / out_stall_i) returns
// exactly one result word per input word, in order.
// An accepted word passes through the issue state and the done state into
// the output register; the timeout query adds a compare state after its
// deadline memory read, and next adds a scan state that reads the deadline
// memory one timer a cycle, ending after the last timer or early once the
// least remaining time reaches zero. One word is worked on at a time; the
// next word is taken once the result has moved into the output register.
// A stalled result holds in the output register; the block accepts the
// next word meanwhile and parks its result until the register frees.
// Reset clears the counter, the running bits, the watch masks and every
// deadline, and sets start_delay to 2000. start_delay is written through
// the APB port at byte addresses 0 to 3 (only paddr[2] is decoded) and
// read back at 0. It is to be written only while the block is idle; the
// block itself does not enforce this.
`timescale 1ns / 1ps
module software_timer_bank import stb_pkg::*; #(
  parameter int unsigned TIMER_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  timer_index_i,
  input  logic [31:0] watch_inputs_i,
  input  logic [31:0] watch_timers_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic        has_value_o,
  output logic [30:0] value_o,
  output logic [1:0]  pop_count_o,
  output logic [31:0] input_mask_out_o
);

  logic [31:0] start_delay_q;
  logic        out_valid_q;
  result_t     out_q, res;
  logic        res_valid, res_ready;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_START_DELAY) ? start_delay_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q <= START_DELAY_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_START_DELAY[2])) begin
      start_delay_q <= pwdata;
    end
  end

  stb_core #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_delay_i  (start_delay_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .timer_index_i  (timer_index_i),
    .watch_inputs_i (watch_inputs_i),
    .watch_timers_i (watch_timers_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  // load the output register when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign has_value_o      = out_q.has_value;
  assign value_o          = out_q.value;
  assign pop_count_o      = out_q.pop_count;
  assign input_mask_out_o = out_q.input_mask_out;

endmodule

// File: sv/stb_ram.sv
`timescale 1ns / 1ps
module stb_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rd_q;
  logic [DEPTH-1:0] vld_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rd_q : 32'd0;

endmodule

// File: sv/stb_core.sv
`timescale 1ns / 1ps
module stb_core import stb_pkg::*; #(
  parameter int unsigned TIMER_COUNT = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] start_delay_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [7:0]  timer_index_i,
  input  logic [31:0] watch_inputs_i,
  input  logic [31:0] watch_timers_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);

  localparam int unsigned IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TIMER_COUNT - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  func_e                  op_q;
  logic [IDX_W-1:0]       idx_q, sc_q, sc_d;
  logic                   idx_ok_q;
  logic [31:0]            now_q, now_d;
  logic [TIMER_COUNT-1:0] run_q, run_d;
  logic [TIMER_COUNT-1:0] wtm_q;
  logic [31:0]            iwatch_q;
  logic [30:0]            best_q, best_d;
  result_t                res_q, res_d;

  logic             accept;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]      ram_wdata, ram_rdata;

  logic [31:0] remain;
  logic [30:0] clamped, best_n;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

  stb_ram #(
    .DEPTH (TIMER_COUNT),
    .AW    (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // remaining time of the entry whose read data is back this cycle
  assign remain  = ram_rdata - now_q;
  assign clamped = remain[31] ? 31'd0 : remain[30:0];
  assign best_n  = (wtm_q[sc_q] && (clamped < best_q)) ? clamped : best_q;

  always_comb begin
    state_d   = state_q;
    now_d     = now_q;
    run_d     = run_q;
    sc_d      = sc_q;
    best_d    = best_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = 32'd0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        res_d   = '0;
        state_d = ST_DONE;
        case (op_q)
          FN_TICK: begin
            now_d = now_q + 32'd1;
          end
          FN_STOP, FN_START, FN_TMO, FN_RUN: begin
            res_d.pop_count = POP_ONE;
            if (!idx_ok_q) begin
              res_d.status = 1'b1;
            end else begin
              case (op_q)
                FN_STOP: begin
                  ram_we       = 1'b1;
                  run_d[idx_q] = 1'b0;
                end
                FN_START: begin
                  ram_we       = 1'b1;
                  ram_wdata    = now_q + start_delay_i;
                  run_d[idx_q] = 1'b1;
                end
                FN_TMO: begin
                  ram_re  = 1'b1;
                  state_d = ST_CMP;
                end
                default: begin
                  res_d.has_value = 1'b1;
                  res_d.value     = {30'd0, run_q[idx_q]};
                end
              endcase
            end
          end
          FN_SELECT: begin
            res_d.pop_count = POP_TWO;
          end
          FN_NEXT: begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            sc_d      = '0;
            best_d    = NO_DEADLINE;
            state_d   = ST_SCAN;
          end
          default: begin
          end
        endcase
      end
      ST_CMP: begin
        res_d.has_value = 1'b1;
        res_d.value     = {30'd0, run_q[idx_q] && (now_q >= ram_rdata)};
        state_d         = ST_DONE;
      end
      ST_SCAN: begin
        best_d = best_n;
        if ((sc_q == LAST) || (best_n == 31'd0)) begin
          res_d.has_value      = 1'b1;
          res_d.value          = best_n;
          res_d.input_mask_out = iwatch_q;
          state_d              = ST_DONE;
        end else begin
          // advance to the next entry, one read a cycle
          ram_re    = 1'b1;
          ram_raddr = sc_q + IDX_W'(1);
          sc_d      = sc_q + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      now_q    <= 32'd0;
      run_q    <= '0;
      wtm_q    <= '0;
      iwatch_q <= 32'd0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      run_q   <= run_d;
      // select takes effect as the word is taken
      if (accept && (func_i == FN_SELECT)) begin
        iwatch_q <= watch_inputs_i;
        wtm_q    <= watch_timers_i[TIMER_COUNT-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= func_e'(func_i);
      idx_q    <= timer_index_i[IDX_W-1:0];
      idx_ok_q <= (timer_index_i < 8'(TIMER_COUNT));
    end
    sc_q   <= sc_d;
    best_q <= best_d;
    res_q  <= res_d;
  end

  a_accept_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_ISSUE))
    else $error("accepted word did not enter issue");

  a_best_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |=> (best_q <= $past(best_q)))
    else $error("scan minimum increased");

  a_err_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && res_q.status) |-> (!res_q.has_value && (res_q.value == 31'd0)))
    else $error("error result carries a value");

  a_pop_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (res_q.pop_count != 2'd3))
    else $error("bad pop count");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) || (state_q == ST_CMP)) |-> (run_d == run_q))
    else $error("running bits changed during a read");

endmodule

// File: tb/software_timer_bank_test.sv
`timescale 1ns / 1ps
module software_timer_bank_test;
  import stb_pkg::*;

  localparam int unsigned TIMERS = 32;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_CYCLES = TIMERS + 8;
  localparam int unsigned PHASES = 6;
  localparam int unsigned WORDS_PER_PHASE = 90;
  localparam int unsigned DIR_ROWS = 25;

  localparam bit FIXED   = 1'b1;
  localparam bit PREDICT = 1'b0;

  localparam result_t TICK_DONE   = '{1'b0, 1'b0, 31'd0, POP_NONE, 32'd0};
  localparam result_t BAD_INDEX   = '{1'b1, 1'b0, 31'd0, POP_ONE, 32'd0};
  localparam result_t ONE_ARG_OK  = '{1'b0, 1'b0, 31'd0, POP_ONE, 32'd0};
  localparam result_t ANSWER_ZERO = '{1'b0, 1'b1, 31'd0, POP_ONE, 32'd0};
  localparam result_t SELECT_DONE = '{1'b0, 1'b0, 31'd0, POP_TWO, 32'd0};
  localparam result_t NONE_WATCHED = '{1'b0, 1'b1, NO_DEADLINE, POP_NONE, 32'd0};

  typedef struct packed {
    func_e       fn;
    logic [7:0]  idx;
    logic [31:0] wi;
    logic [31:0] wt;
    logic        fixed;
    result_t     res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  func_i;
  logic [7:0]  timer_index_i;
  logic [31:0] watch_inputs_i;
  logic [31:0] watch_timers_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        status_o;
  logic        has_value_o;
  logic [30:0] value_o;
  logic [1:0]  pop_count_o;
  logic [31:0] input_mask_out_o;

  software_timer_bank #(.TIMER_COUNT(TIMERS)) dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .func_i, .timer_index_i, .watch_inputs_i,
    .watch_timers_i, .out_valid_o, .out_stall_i, .status_o, .has_value_o,
    .value_o, .pop_count_o, .input_mask_out_o
  );

  // timer bank image kept alongside the block
  logic [31:0] delay_ms;
  logic [31:0] tick_count;
  logic [31:0] deadline_ms [TIMERS];
  logic [31:0] armed_bits;
  logic [31:0] watched_inputs;
  logic [31:0] watched_timers;

  result_t pending_results [$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned expired_seen;
  int unsigned range_errors;
  int unsigned scans_seen;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{FN_RUN,    8'd0,   32'd0,          32'd0,          FIXED,   ANSWER_ZERO},
    '{FN_TMO,    8'd0,   32'd0,          32'd0,          FIXED,   ANSWER_ZERO},
    '{FN_NEXT,   8'd0,   32'd0,          32'd0,          FIXED,   NONE_WATCHED},
    '{FN_TICK,   8'd0,   32'd0,          32'd0,          FIXED,   TICK_DONE},
    '{FN_TMO,    8'd32,  32'd0,          32'd0,          FIXED,   BAD_INDEX},
    '{FN_STOP,   8'd255, 32'd0,          32'd0,          FIXED,   BAD_INDEX},
    '{FN_START,  8'd255, 32'd0,          32'd0,          FIXED,   BAD_INDEX},
    '{FN_RUN,    8'd128, 32'd0,          32'd0,          FIXED,   BAD_INDEX},
    '{FN_SELECT, 8'd0,   32'hffff_ffff,  32'hffff_ffff,  FIXED,   SELECT_DONE},
    // every deadline already behind: scan stops on the first timer
    '{FN_NEXT,   8'd0,   32'd0,          32'd0,          FIXED,
      '{1'b0, 1'b1, 31'd0, POP_NONE, 32'hffff_ffff}},
    '{FN_START,  8'd31,  32'd0,          32'd0,          PREDICT, '0},
    '{FN_START,  8'd0,   32'd0,          32'd0,          PREDICT, '0},
    '{FN_RUN,    8'd31,  32'd0,          32'd0,          PREDICT, '0},
    '{FN_TMO,    8'd31,  32'd0,          32'd0,          PREDICT, '0},
    '{FN_SELECT, 8'd0,   32'd0,          32'h8000_0000,  FIXED,   SELECT_DONE},
    '{FN_NEXT,   8'd0,   32'd0,          32'd0,          PREDICT, '0},
    '{FN_TICK,   8'd0,   32'd0,          32'd0,          FIXED,   TICK_DONE},
    '{FN_NEXT,   8'd0,   32'd0,          32'd0,          PREDICT, '0},
    '{FN_SELECT, 8'd0,   32'ha5a5_a5a5,  32'h0000_0001,  FIXED,   SELECT_DONE},
    '{FN_NEXT,   8'd0,   32'd0,          32'd0,          PREDICT, '0},
    '{FN_STOP,   8'd31,  32'd0,          32'd0,          FIXED,   ONE_ARG_OK},
    '{FN_RUN,    8'd31,  32'd0,          32'd0,          FIXED,   ANSWER_ZERO},
    '{FN_TMO,    8'd31,  32'd0,          32'd0,          FIXED,   ANSWER_ZERO},
    '{FN_SELECT, 8'd0,   32'd0,          32'd0,          FIXED,   SELECT_DONE},
    '{FN_NEXT,   8'd0,   32'd0,          32'd0,          FIXED,   NONE_WATCHED}
  };

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] least_slack();
    logic [31:0] best;
    logic [31:0] slack;
    best = {1'b0, NO_DEADLINE};
    for (int t = 0; t < TIMERS && best != 32'd0; t++) begin
      if (watched_timers[t]) begin
        slack = deadline_ms[t] - tick_count;
        if (slack[31]) slack = 32'd0;
        if (slack < best) best = slack;
      end
    end
    return best;
  endfunction

  function automatic result_t predict_timer_op(input func_e fn, input logic [7:0] idx,
                                               input logic [31:0] wi, input logic [31:0] wt);
    result_t r;
    logic [31:0] slack;
    r = '0;
    case (fn)
      FN_TICK: tick_count = tick_count + 32'd1;
      FN_STOP, FN_START, FN_TMO, FN_RUN: begin
        r.pop_count = POP_ONE;
        if (idx >= TIMERS) begin
          r.status = 1'b1;
        end else if (fn == FN_STOP) begin
          armed_bits[idx] = 1'b0;
          deadline_ms[idx] = 32'd0;
        end else if (fn == FN_START) begin
          armed_bits[idx] = 1'b1;
          deadline_ms[idx] = tick_count + delay_ms;
        end else if (fn == FN_TMO) begin
          r.has_value = 1'b1;
          r.value = {30'd0, armed_bits[idx] && (tick_count >= deadline_ms[idx])};
        end else begin
          r.has_value = 1'b1;
          r.value = {30'd0, armed_bits[idx]};
        end
      end
      FN_SELECT: begin
        watched_inputs = wi;
        watched_timers = wt;
        r.pop_count = POP_TWO;
      end
      FN_NEXT: begin
        slack = least_slack();
        r.has_value = 1'b1;
        r.value = slack[30:0];
        r.input_mask_out = watched_inputs;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(input func_e fn, input logic [7:0] idx, input logic [31:0] wi,
                           input logic [31:0] wt, input logic fixed, input result_t fixed_res);
    result_t predicted;
    in_valid_i     <= 1'b1;
    func_i         <= fn;
    timer_index_i  <= idx;
    watch_inputs_i <= wi;
    watch_timers_i <= wt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_timer_op(fn, idx, wi, wt);
    pending_results.push_back(fixed ? fixed_res : predicted);
    words_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic write_start_delay(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_START_DELAY;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    delay_ms = v;
    // read it back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("start_delay readback: expected %h got %h", v, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_random_word();
    func_e       fn;
    logic [7:0]  idx;
    logic [31:0] wt;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 28)      fn = FN_TICK;
    else if (pick < 36) fn = FN_STOP;
    else if (pick < 52) fn = FN_START;
    else if (pick < 66) fn = FN_TMO;
    else if (pick < 76) fn = FN_RUN;
    else if (pick < 84) fn = FN_SELECT;
    else                fn = FN_NEXT;
    // keep most indexes on a few timers so they get started, expire and stop
    pick = $urandom_range(99);
    if (pick < 60)      idx = 8'($urandom_range(7));
    else if (pick < 90) idx = 8'($urandom_range(TIMERS - 1));
    else                idx = 8'($urandom_range(255, TIMERS));
    pick = $urandom_range(99);
    if (pick < 40)      wt = $urandom_range(255);
    else if (pick < 60) wt = 32'hffff_ffff;
    else if (pick < 70) wt = 32'd0;
    else                wt = $urandom;
    send_word(fn, idx, $urandom, wt, PREDICT, '0);
  endtask

  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_served + 1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_o, has_value_o, value_o, pop_count_o, input_mask_out_o};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: %p", got);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (got.status) range_errors++;
        if (got.input_mask_out != 32'd0 || got.value > 31'd1) scans_seen++;
        if (got.has_value && got.pop_count == POP_ONE && got.value == 31'd1) expired_seen++;
        if (got.status !== want.status || got.has_value !== want.has_value ||
            got.value !== want.value || got.pop_count !== want.pop_count ||
            got.input_mask_out !== want.input_mask_out) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("word %0d: expected st=%0b hv=%0b val=%h pop=%0d mask=%h, got st=%0b hv=%0b val=%h pop=%0d mask=%h",
                     words_checked, want.status, want.has_value, want.value,
                     want.pop_count, want.input_mask_out, got.status, got.has_value,
                     got.value, got.pop_count, got.input_mask_out);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] delays [PHASES];
    int unsigned snd_pct [PHASES];
    int unsigned rcv_pct [PHASES];
    delays  = '{32'd3, 32'hffff_ffff, 32'd17, 32'h8000_0000, 32'h7fff_ffff, 32'd0};
    snd_pct = '{29, 29, 58, 58, 0, 0};
    rcv_pct = '{58, 58, 29, 29, 0, 0};

    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = REG_START_DELAY;
    pwdata = 32'd0;
    in_valid_i = 1'b0;
    func_i = FN_TICK;
    timer_index_i = 8'd0;
    watch_inputs_i = 32'd0;
    watch_timers_i = 32'd0;
    sender_idle_pct = snd_pct[0];
    receiver_stall_pct = rcv_pct[0];
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    words_sent = 0;
    words_checked = 0;
    expired_seen = 0;
    range_errors = 0;
    scans_seen = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    delay_ms = START_DELAY_RESET;
    tick_count = 32'd0;
    armed_bits = 32'd0;
    watched_inputs = 32'd0;
    watched_timers = 32'd0;
    for (int t = 0; t < TIMERS; t++) deadline_ms[t] = 32'd0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].fn, dir_rows[i].idx, dir_rows[i].wi, dir_rows[i].wt,
                dir_rows[i].fixed, dir_rows[i].res);
    in_valid_i <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_start_delay(delays[p]);
      sender_idle_pct = snd_pct[p];
      receiver_stall_pct = rcv_pct[p];
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // hold the result side off while words keep coming so the block backs up
        if (p == 4 && n == 20) hold_requests = hold_requests + 1;
        send_random_word();
      end
      in_valid_i <= 1'b0;
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d words over %0d start_delay settings, %0d results checked",
             words_sent, PHASES + 1, words_checked);
    $display("%0d expired or running answers, %0d bad indexes, %0d scans with a slack",
             expired_seen, range_errors, scans_seen);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
